>>> hw/rtl/ltm_pkg.sv
// shared types and constants of the tunnel texture mapper
package ltm_pkg;

    // request kinds carried on s_tuser
    localparam int FUNC_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TEXEL = 2'd0,
        FUNC_TABLE = 2'd1,
        FUNC_DRAW  = 2'd2
    } func_t;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHIFT_U  = 2'd0,
        CFG_SHIFT_V  = 2'd1,
        CFG_LOOK_COL = 2'd2,
        CFG_LOOK_ROW = 2'd3
    } cfg_idx_t;

    localparam logic [15:0] SHIFT_U_RST  = 16'd0;
    localparam logic [15:0] SHIFT_V_RST  = 16'd0;
    localparam logic [7:0]  LOOK_COL_RST = 8'd80;
    localparam logic [6:0]  LOOK_ROW_RST = 7'd0;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic [6:0]         pad;
        logic [7:0]         shade_value;
        logic signed [15:0] angle_value;
        logic signed [15:0] depth_value;
        logic [7:0]         tex_blue;
        logic [7:0]         tex_green;
        logic [7:0]         tex_red;
        logic [7:0]         row;
        logic [8:0]         col;
    } in_data_t;

    typedef struct packed {
        logic       pad;
        logic [7:0] pix_blue;
        logic [7:0] pix_green;
        logic [7:0] pix_red;
        logic [6:0] pix_row;
        logic [7:0] pix_col;
    } out_data_t;

    // per-request control carried down the pipeline
    typedef struct packed {
        logic       draw;
        logic       tbl_wr;
        logic       tex_wr;
        logic [8:0] col;
        logic [7:0] row;
    } tag_t;

    // table position sums: col + look_col and row + look_row
    localparam int SX_W = 10;
    localparam int SY_W = 9;

    // result queue
    localparam int OQ_DEPTH  = 16;
    localparam int OQ_PTR_W  = 4;
    localparam int OQ_CNT_W  = 5;

endpackage

>>> hw/rtl/lut_tunnel_texture_mapper.sv
// tunnel texture mapper: table lookup, texture fetch and shading pipeline
// throughput: one request per cycle while s_tready is high; table and texture each use one read/write port
// up to 16 requests may be in flight or queued; s_tready drops only at that limit
// reset clears the valid bits, the result queue and the registers (look_col to 80)
// the texture and table memories are not cleared and hold nothing until written
module lut_tunnel_texture_mapper #(
    parameter int TEX_W    = 64,
    parameter int TEX_H    = 64,
    parameter int TABLE_W  = 320,
    parameter int TABLE_H  = 240,
    parameter int SCREEN_W = 160,
    parameter int SCREEN_H = 120
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // col, row, tex_red, tex_green, tex_blue, depth_value, angle_value, shade_value, zero pad
    input  logic [ltm_pkg::IN_DATA_W-1:0]    s_tdata,
    // func
    input  logic [ltm_pkg::FUNC_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pix_col, pix_row, pix_red, pix_green, pix_blue, zero pad
    output logic [ltm_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ltm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ltm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ltm_pkg::*;

    localparam int NSTG     = 13;
    localparam int STG_TBL  = 4;
    localparam int STG_TEX  = 10;
    localparam int STG_LAST = NSTG - 1;

    localparam int TC_W      = $clog2(TABLE_W);
    localparam int TR_W      = $clog2(TABLE_H);
    localparam int TBL_DEPTH = TABLE_W * TABLE_H;
    localparam int TA_W      = $clog2(TBL_DEPTH);
    localparam int TU_W      = $clog2(TEX_W);
    localparam int TV_W      = $clog2(TEX_H);
    localparam int TEX_DEPTH = TEX_W * TEX_H;
    localparam int XA_W      = $clog2(TEX_DEPTH);

    // reciprocals for the modulo stages, exact after one correction step
    localparam logic [SX_W-1:0] RECIP_X = SX_W'((1 << SX_W) / TABLE_W);
    localparam logic [SY_W-1:0] RECIP_Y = SY_W'((1 << SY_W) / TABLE_H);
    localparam logic [15:0]     RECIP_U = 16'(65536 / TEX_W);
    localparam logic [15:0]     RECIP_V = 16'(65536 / TEX_H);

    // floor(p / 255) for p up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = 17'(p) + 17'(p[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    // ---------------- configuration ----------------
    logic [15:0] shift_u_reg, shift_v_reg;
    logic [7:0]  look_col_reg;
    logic [6:0]  look_row_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_u_reg  <= SHIFT_U_RST;
            shift_v_reg  <= SHIFT_V_RST;
            look_col_reg <= LOOK_COL_RST;
            look_row_reg <= LOOK_ROW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SHIFT_U:  shift_u_reg  <= cfg_data;
                CFG_SHIFT_V:  shift_v_reg  <= cfg_data;
                CFG_LOOK_COL: look_col_reg <= cfg_data[7:0];
                CFG_LOOK_ROW: look_row_reg <= cfg_data[6:0];
                default:      ;
            endcase
        end
    end

    // ---------------- input decode ----------------
    in_data_t       in_d;
    tag_t           tag_in;
    logic           s_acc;
    logic [SX_W-1:0] sx_in;
    logic [SY_W-1:0] sy_in;

    assign in_d  = in_data_t'(s_tdata);
    assign s_acc = s_tvalid && s_tready;

    always_comb
    begin
        tag_in.col    = in_d.col;
        tag_in.row    = in_d.row;
        tag_in.draw   = (s_tuser == FUNC_DRAW) && (in_d.col < SCREEN_W) &&
                        (in_d.row < SCREEN_H);
        tag_in.tbl_wr = (s_tuser == FUNC_TABLE) && (in_d.col < TABLE_W) &&
                        (in_d.row < TABLE_H);
        tag_in.tex_wr = (s_tuser == FUNC_TEXEL) && (in_d.col < TEX_W) &&
                        (in_d.row < TEX_H);
        if (s_tuser == FUNC_DRAW)
        begin
            sx_in = SX_W'(in_d.col) + SX_W'(look_col_reg);
            sy_in = SY_W'(in_d.row) + SY_W'(look_row_reg);
        end
        else
        begin
            sx_in = SX_W'(in_d.col);
            sy_in = SY_W'(in_d.row);
        end
    end

    // ---------------- pipeline ----------------
    logic [NSTG-1:0] vld_reg;
    tag_t            tag_reg [NSTG];
    logic [39:0]     twd_reg [STG_TBL+1];
    logic [23:0]     rgb_reg [STG_TEX+1];
    logic [7:0]      shd_reg [STG_TBL+2:STG_TEX+1];

    logic [SX_W-1:0]   sx0_reg, sx1_reg, rx2_reg;
    logic [SY_W-1:0]   sy0_reg, sy1_reg, ry2_reg;
    logic [2*SX_W-1:0] px1_reg;
    logic [2*SY_W-1:0] py1_reg;
    logic [TC_W-1:0]   tc3_reg;
    logic [TR_W-1:0]   tr3_reg;
    logic [TA_W-1:0]   ta4_reg;
    logic [39:0]       tbl_q_reg;
    logic [15:0]       u6_reg, v6_reg, u7_reg, v7_reg, ru8_reg, rv8_reg;
    logic [31:0]       pu7_reg, pv7_reg;
    logic [TU_W-1:0]   tu9_reg;
    logic [TV_W-1:0]   tv9_reg;
    logic [XA_W-1:0]   xa10_reg;
    logic [23:0]       tex_q_reg;
    logic [15:0]       pr12_reg, pg12_reg, pb12_reg;

    logic [39:0] tbl_mem [TBL_DEPTH];
    logic [23:0] tex_mem [TEX_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NSTG-2:0], s_acc};
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= tag_in;
        for (int k = 1; k < NSTG; k++)
            tag_reg[k] <= tag_reg[k-1];

        twd_reg[0] <= {in_d.depth_value, in_d.angle_value, in_d.shade_value};
        for (int k = 1; k <= STG_TBL; k++)
            twd_reg[k] <= twd_reg[k-1];

        rgb_reg[0] <= {in_d.tex_red, in_d.tex_green, in_d.tex_blue};
        for (int k = 1; k <= STG_TEX; k++)
            rgb_reg[k] <= rgb_reg[k-1];

        // table position modulo table size
        sx0_reg <= sx_in;
        sy0_reg <= sy_in;
        px1_reg <= (2*SX_W)'(sx0_reg) * (2*SX_W)'(RECIP_X);
        py1_reg <= (2*SY_W)'(sy0_reg) * (2*SY_W)'(RECIP_Y);
        sx1_reg <= sx0_reg;
        sy1_reg <= sy0_reg;
        rx2_reg <= sx1_reg - SX_W'(px1_reg[2*SX_W-1:SX_W] * TABLE_W);
        ry2_reg <= sy1_reg - SY_W'(py1_reg[2*SY_W-1:SY_W] * TABLE_H);
        tc3_reg <= (rx2_reg >= TABLE_W) ? TC_W'(int'(rx2_reg) - TABLE_W) : TC_W'(rx2_reg);
        tr3_reg <= (ry2_reg >= TABLE_H) ? TR_W'(int'(ry2_reg) - TABLE_H) : TR_W'(ry2_reg);
        ta4_reg <= TA_W'(tr3_reg * TABLE_W + tc3_reg);

        // texture coordinates; texel writes take their position as is
        if (tag_reg[STG_TBL+1].tex_wr)
        begin
            u6_reg <= 16'(tag_reg[STG_TBL+1].col);
            v6_reg <= 16'(tag_reg[STG_TBL+1].row);
        end
        else
        begin
            u6_reg <= tbl_q_reg[39:24] + shift_u_reg;
            v6_reg <= tbl_q_reg[23:8] + shift_v_reg;
        end
        shd_reg[STG_TBL+2] <= tbl_q_reg[7:0];
        for (int k = STG_TBL + 3; k <= STG_TEX + 1; k++)
            shd_reg[k] <= shd_reg[k-1];

        pu7_reg  <= 32'(u6_reg) * 32'(RECIP_U);
        pv7_reg  <= 32'(v6_reg) * 32'(RECIP_V);
        u7_reg   <= u6_reg;
        v7_reg   <= v6_reg;
        ru8_reg  <= u7_reg - 16'(pu7_reg[31:16] * TEX_W);
        rv8_reg  <= v7_reg - 16'(pv7_reg[31:16] * TEX_H);
        tu9_reg  <= (ru8_reg >= TEX_W) ? TU_W'(int'(ru8_reg) - TEX_W) : TU_W'(ru8_reg);
        tv9_reg  <= (rv8_reg >= TEX_H) ? TV_W'(int'(rv8_reg) - TEX_H) : TV_W'(rv8_reg);
        xa10_reg <= XA_W'(tv9_reg * TEX_W + tu9_reg);

        // shading products
        pr12_reg <= 16'(tex_q_reg[23:16]) * 16'(shd_reg[STG_TEX+1]);
        pg12_reg <= 16'(tex_q_reg[15:8]) * 16'(shd_reg[STG_TEX+1]);
        pb12_reg <= 16'(tex_q_reg[7:0]) * 16'(shd_reg[STG_TEX+1]);
    end

    // table memory: writes and reads at the same stage keep request order
    always_ff @(posedge clk)
    begin
        if (vld_reg[STG_TBL] && tag_reg[STG_TBL].tbl_wr)
            tbl_mem[ta4_reg] <= twd_reg[STG_TBL];
        tbl_q_reg <= tbl_mem[ta4_reg];
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[STG_TEX] && tag_reg[STG_TEX].tex_wr)
            tex_mem[xa10_reg] <= rgb_reg[STG_TEX];
        tex_q_reg <= tex_mem[xa10_reg];
    end

    // ---------------- result queue ----------------
    out_data_t            oq_din;
    logic [OUT_DATA_W-1:0] oq_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  oq_wr_reg, oq_rd_reg;
    logic [OQ_CNT_W-1:0]  oq_cnt_reg, oq_cnt_next;
    logic [OQ_CNT_W-1:0]  used_reg, used_next;
    logic                 oq_push, oq_pop, drop;

    always_comb
    begin
        oq_din.pad       = 1'b0;
        oq_din.pix_col   = tag_reg[STG_LAST].col[7:0];
        oq_din.pix_row   = tag_reg[STG_LAST].row[6:0];
        oq_din.pix_red   = div255(pr12_reg);
        oq_din.pix_green = div255(pg12_reg);
        oq_din.pix_blue  = div255(pb12_reg);
    end

    assign oq_push  = vld_reg[STG_LAST] && tag_reg[STG_LAST].draw;
    assign drop     = vld_reg[STG_LAST] && !tag_reg[STG_LAST].draw;
    assign m_tvalid = (oq_cnt_reg != '0);
    assign m_tdata  = oq_mem[oq_rd_reg];
    assign oq_pop   = m_tvalid && m_tready;
    // every accepted request holds a slot until its result leaves or it proves to have none
    assign s_tready = (used_reg < OQ_CNT_W'(OQ_DEPTH));

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
        used_next   = used_reg + OQ_CNT_W'(s_acc) - OQ_CNT_W'(oq_pop) - OQ_CNT_W'(drop);
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_mem[oq_wr_reg] <= oq_din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
            used_reg   <= '0;
        end
        else
        begin
            if (oq_push)
                oq_wr_reg <= oq_wr_reg + OQ_PTR_W'(1);
            if (oq_pop)
                oq_rd_reg <= oq_rd_reg + OQ_PTR_W'(1);
            oq_cnt_reg <= oq_cnt_next;
            used_reg   <= used_next;
        end
    end

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("outstanding request count above queue depth");

    a_queue_within_used: assert property (@(posedge clk) disable iff (!rst_n)
        oq_cnt_reg <= used_reg)
        else $error("queue holds more results than outstanding requests");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |-> (oq_cnt_reg < OQ_CNT_W'(OQ_DEPTH)) || oq_pop)
        else $error("result pushed into full queue");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> $countones({tag_reg[0].draw, tag_reg[0].tbl_wr, tag_reg[0].tex_wr}) <= 1)
        else $error("request decoded to more than one action");

    a_accept_takes_slot: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && !oq_pop && !drop |=> used_reg == $past(used_reg) + OQ_CNT_W'(1))
        else $error("accepted request not counted");
`endif

endmodule

>>> verif/tb_lut_tunnel_texture_mapper.sv
// self-checking bench for the tunnel texture mapper: predicts every drawn pixel and compares
`timescale 1ns / 100ps

module tb_lut_tunnel_texture_mapper;
    import ltm_pkg::*;

    localparam int TEX_W    = 64;
    localparam int TEX_H    = 64;
    localparam int TABLE_W  = 320;
    localparam int TABLE_H  = 240;
    localparam int SCREEN_W = 160;
    localparam int SCREEN_H = 120;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 325;
    localparam int SETTLE_CYCLES = 32;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int REPORT_MAX    = 10;

    // predicts shaded pixels from its own copy of the stores and registers
    class pixel_predictor;
        logic [23:0] texels [TEX_W*TEX_H];
        bit          texel_set [TEX_W*TEX_H];
        logic [15:0] depth_tab [TABLE_W*TABLE_H];
        logic [15:0] angle_tab [TABLE_W*TABLE_H];
        logic [7:0]  shade_tab [TABLE_W*TABLE_H];
        bit          entry_set [TABLE_W*TABLE_H];
        logic [15:0] shift_u;
        logic [15:0] shift_v;
        logic [7:0]  look_col;
        logic [6:0]  look_row;
        out_data_t   expected_pixels [$];
        int          fail_count;
        int          live_requests;

        function new();
            shift_u  = SHIFT_U_RST;
            shift_v  = SHIFT_V_RST;
            look_col = LOOK_COL_RST;
            look_row = LOOK_ROW_RST;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] value);
            case (idx)
                CFG_SHIFT_U:  shift_u  = value;
                CFG_SHIFT_V:  shift_v  = value;
                CFG_LOOK_COL: look_col = value[7:0];
                CFG_LOOK_ROW: look_row = value[6:0];
                default: ;
            endcase
        endfunction

        // table entry seen by a screen pixel through the view window
        function int unsigned entry_of(int unsigned c, int unsigned r);
            return ((r + look_row) % TABLE_H) * TABLE_W + (c + look_col) % TABLE_W;
        endfunction

        function int unsigned texel_of(int unsigned at);
            logic [15:0] u;
            logic [15:0] v;
            u = depth_tab[at] + shift_u;
            v = angle_tab[at] + shift_v;
            return (v % TEX_H) * TEX_W + (u % TEX_W);
        endfunction

        function logic [7:0] shaded(logic [7:0] chan, logic [7:0] s);
            int unsigned prod;
            prod = chan * s;
            return 8'(prod / 255);
        endfunction

        function void note_request(logic [FUNC_W-1:0] f, in_data_t d);
            int unsigned at;
            int unsigned ti;
            out_data_t   px;
            if (f == FUNC_TEXEL && d.col < TEX_W && d.row < TEX_H)
            begin
                texels[d.row * TEX_W + d.col]    = {d.tex_red, d.tex_green, d.tex_blue};
                texel_set[d.row * TEX_W + d.col] = 1'b1;
                live_requests++;
            end
            else if (f == FUNC_TABLE && d.col < TABLE_W && d.row < TABLE_H)
            begin
                at            = d.row * TABLE_W + d.col;
                depth_tab[at] = d.depth_value;
                angle_tab[at] = d.angle_value;
                shade_tab[at] = d.shade_value;
                entry_set[at] = 1'b1;
                live_requests++;
            end
            else if (f == FUNC_DRAW && d.col < SCREEN_W && d.row < SCREEN_H)
            begin
                at           = entry_of(d.col, d.row);
                ti           = texel_of(at);
                px           = '0;
                px.pix_col   = d.col[7:0];
                px.pix_row   = d.row[6:0];
                px.pix_red   = shaded(texels[ti][23:16], shade_tab[at]);
                px.pix_green = shaded(texels[ti][15:8], shade_tab[at]);
                px.pix_blue  = shaded(texels[ti][7:0], shade_tab[at]);
                expected_pixels.push_back(px);
                live_requests++;
            end
        endfunction

        function void check_pixel(out_data_t got);
            out_data_t want;
            if (expected_pixels.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("pixel with none expected: col %0d row %0d rgb %02h %02h %02h",
                             got.pix_col, got.pix_row, got.pix_red, got.pix_green,
                             got.pix_blue);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pix_col !== want.pix_col || got.pix_row !== want.pix_row ||
                got.pix_red !== want.pix_red || got.pix_green !== want.pix_green ||
                got.pix_blue !== want.pix_blue)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display({"pixel mismatch: expected col %0d row %0d rgb %02h %02h %02h,",
                              " got col %0d row %0d rgb %02h %02h %02h"},
                             want.pix_col, want.pix_row, want.pix_red, want.pix_green,
                             want.pix_blue, got.pix_col, got.pix_row, got.pix_red,
                             got.pix_green, got.pix_blue);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [FUNC_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pixel_predictor pred;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             cycle_count   = 0;

    lut_tunnel_texture_mapper #(
        .TEX_W    (TEX_W),
        .TEX_H    (TEX_H),
        .TABLE_W  (TABLE_W),
        .TABLE_H  (TABLE_H),
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            pred.check_pixel(out_data_t'(m_tdata));
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("[lut_tunnel_texture_mapper] ERROR");
            $finish;
        end
    end

    function automatic in_data_t random_fields();
        logic [95:0] bits;
        in_data_t    d;
        bits  = {$urandom, $urandom, $urandom};
        d     = bits[IN_DATA_W-1:0];
        d.pad = '0;
        return d;
    endfunction

    task automatic send(logic [FUNC_W-1:0] f, int unsigned c, int unsigned r, in_data_t d);
        d.col = c[8:0];
        d.row = r[7:0];
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= f;
        do @(posedge clk); while (!s_tready);
        pred.note_request(f, d);
    endtask

    // loads the table entry and texel the pixel will read when missing or on reload, then draws it
    task automatic draw_pixel(int unsigned c, int unsigned r, bit reload, in_data_t vals);
        int unsigned at;
        int unsigned ti;
        at = pred.entry_of(c, r);
        if (reload || !pred.entry_set[at])
            send(FUNC_TABLE, at % TABLE_W, at / TABLE_W, vals);
        ti = pred.texel_of(at);
        if (reload || !pred.texel_set[ti])
            send(FUNC_TEXEL, ti % TEX_W, ti / TEX_W, vals);
        send(FUNC_DRAW, c, r, random_fields());
    endtask

    // requests the block must drop without a trace
    task automatic send_ignored();
        bit pick_col;
        pick_col = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: send(FUNC_TEXEL, pick_col ? $urandom_range(TEX_W, 511) : $urandom_range(0, 511),
                    pick_col ? $urandom_range(0, 255) : $urandom_range(TEX_H, 255),
                    random_fields());
            1: send(FUNC_TABLE,
                    pick_col ? $urandom_range(TABLE_W, 511) : $urandom_range(0, 511),
                    pick_col ? $urandom_range(0, 255) : $urandom_range(TABLE_H, 255),
                    random_fields());
            2: send(FUNC_DRAW,
                    pick_col ? $urandom_range(SCREEN_W, 511) : $urandom_range(0, 511),
                    pick_col ? $urandom_range(0, 255) : $urandom_range(SCREEN_H, 255),
                    random_fields());
            default: send(FUNC_UNUSED, $urandom_range(0, 511), $urandom_range(0, 255),
                          random_fields());
        endcase
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        pred.set_reg(idx, value);
    endtask

    task automatic cfg_setup(logic [15:0] su, logic [15:0] sv, logic [15:0] lc, logic [15:0] lr);
        cfg_write(CFG_SHIFT_U, su);
        cfg_write(CFG_SHIFT_V, sv);
        cfg_write(CFG_LOOK_COL, lc);
        cfg_write(CFG_LOOK_ROW, lr);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        in_data_t d;
        d = random_fields();
        d.tex_red = 8'hFF; d.tex_green = 8'hFF; d.tex_blue = 8'hFF;
        d.depth_value = 16'sh8000; d.angle_value = 16'sh7FFF; d.shade_value = 8'hFF;
        send(FUNC_TEXEL, 0, 0, d);
        send(FUNC_TABLE, 0, 0, d);
        draw_pixel(0, 0, 1'b1, d);
        d.tex_red = 8'hFF; d.tex_green = 8'h00; d.tex_blue = 8'h80;
        d.depth_value = 16'sh7FFF; d.angle_value = 16'sh8000; d.shade_value = 8'h00;
        send(FUNC_TEXEL, TEX_W - 1, TEX_H - 1, d);
        send(FUNC_TABLE, TABLE_W - 1, TABLE_H - 1, d);
        draw_pixel(SCREEN_W - 1, SCREEN_H - 1, 1'b1, d);
        d = random_fields();
        d.tex_red = 8'hFF; d.tex_green = 8'h01; d.tex_blue = 8'hFE; d.shade_value = 8'h80;
        draw_pixel(1, 0, 1'b1, d);
        // requests that fall outside a store, the screen or the func codes
        send(FUNC_TEXEL, TEX_W, 0, random_fields());
        send(FUNC_TEXEL, 0, TEX_H, random_fields());
        send(FUNC_TEXEL, 511, 255, random_fields());
        send(FUNC_TABLE, TABLE_W, 0, random_fields());
        send(FUNC_TABLE, 0, TABLE_H, random_fields());
        send(FUNC_TABLE, 511, 255, random_fields());
        send(FUNC_DRAW, SCREEN_W, 0, random_fields());
        send(FUNC_DRAW, 0, SCREEN_H, random_fields());
        send(FUNC_DRAW, 511, 255, random_fields());
        send(FUNC_UNUSED, 0, 0, random_fields());
        draw_pixel(0, 0, 1'b0, random_fields());
    endtask

    task automatic run_random();
        int          start;
        int unsigned pick;
        int unsigned c;
        int unsigned r;
        int unsigned at;
        start = pred.live_requests;
        while (pred.live_requests - start < PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            // half the pixels come from a small corner so entries get reused
            if ($urandom_range(0, 1))
            begin
                c = $urandom_range(0, 7);
                r = $urandom_range(0, 3);
            end
            else
            begin
                c = $urandom_range(0, SCREEN_W - 1);
                r = $urandom_range(0, SCREEN_H - 1);
            end
            if (pick < 60)
                draw_pixel(c, r, 1'b0, random_fields());
            else if (pick < 66)
                draw_pixel(c, r, 1'b1, random_fields());
            else if (pick < 76)
                send(FUNC_TEXEL, $urandom_range(0, TEX_W - 1), $urandom_range(0, TEX_H - 1),
                     random_fields());
            else if (pick < 86)
            begin
                at = pred.entry_of(c, r);
                send(FUNC_TABLE, at % TABLE_W, at / TABLE_W, random_fields());
            end
            else
                send_ignored();
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic settle();
        while (pred.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        pred      = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_TEXEL;
        cfg_valid = 1'b0;
        cfg_index = CFG_SHIFT_U;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p / 2)
                0:
                begin
                    send_idle_pct = 26;
                    recv_idle_pct = 81;
                end
                1:
                begin
                    send_idle_pct = 81;
                    recv_idle_pct = 26;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (p)
                0: cfg_setup(SHIFT_U_RST, SHIFT_V_RST, 16'(LOOK_COL_RST), 16'(LOOK_ROW_RST));
                1: cfg_setup(16'hFFFF, 16'hFFFF, 16'(TABLE_W - SCREEN_W),
                             16'(TABLE_H - SCREEN_H));
                2: cfg_setup(16'd0, 16'd0, 16'd0, 16'd0);
                default: cfg_setup(16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, TABLE_W - SCREEN_W)),
                                   16'($urandom_range(0, TABLE_H - SCREEN_H)));
            endcase
            if (p == 0)
                run_directed();
            run_random();
            settle();
        end
        if (pred.fail_count == 0 && pred.pending() == 0)
            $display("[lut_tunnel_texture_mapper] OK");
        else
            $display("[lut_tunnel_texture_mapper] ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ltm_pkg.sv
hw/rtl/lut_tunnel_texture_mapper.sv
verif/tb_lut_tunnel_texture_mapper.sv
